// ===== hdl/psa_pkg.sv =====
package psa_pkg;

  localparam int unsigned NUM_ENTRIES_DEF = 8;

  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned INDEX_W   = 3;
  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned WAIT_W    = 11;
  localparam int unsigned LEN_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 10;

  localparam logic [PRIO_W-1:0] PRIO_MAX         = 8'hFF;
  localparam logic [LEN_W-1:0]  SLICE_LENGTH_RST = 10'd500;
  localparam logic [LEN_W-1:0]  AGING_THRESH_RST = 10'd1000;
  localparam logic              AGING_ENABLE_RST = 1'b1;

  typedef enum logic [1:0] {
    ST_EMPTY,
    ST_READY,
    ST_FINISHED
  } entry_state_e;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD,
    OP_FINISH,
    OP_SLICE
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLICE_LENGTH,
    CFG_AGING_THRESHOLD,
    CFG_AGING_ENABLE
  } cfg_reg_e;

  typedef struct packed {
    entry_state_e      st;
    logic [PRIO_W-1:0] prio;
    logic [WAIT_W-1:0] wait_time;
  } entry_t;

endpackage

// ===== hdl/psa_in_if.sv =====
interface psa_in_if;
  logic                          valid;
  logic                          ready;
  logic [psa_pkg::OPCODE_W-1:0]  opcode;
  logic [psa_pkg::INDEX_W-1:0]   entry_index;
  logic [psa_pkg::PRIO_W-1:0]    new_priority;

  modport source (output valid, output opcode, output entry_index, output new_priority,
                  input ready);
  modport sink (input valid, input opcode, input entry_index, input new_priority,
                output ready);
endinterface

// ===== hdl/psa_out_if.sv =====
interface psa_out_if;
  logic                         valid;
  logic                         ready;
  logic                         grant_valid;
  logic [psa_pkg::INDEX_W-1:0]  grant_index;
  logic [psa_pkg::PRIO_W-1:0]   grant_priority;

  modport source (output valid, output grant_valid, output grant_index,
                  output grant_priority, input ready);
  modport sink (input valid, input grant_valid, input grant_index, input grant_priority,
                output ready);
endinterface

// ===== hdl/psa_cfg_if.sv =====
interface psa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [psa_pkg::CFG_IDX_W-1:0]  index;
  logic [psa_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/psa_entry_mem.sv =====
module psa_entry_mem #(
  parameter int unsigned NumEntries = psa_pkg::NUM_ENTRIES_DEF,
  localparam int unsigned IdxW = $clog2(NumEntries)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [IdxW-1:0]   waddr_i,
  input  psa_pkg::entry_t   wdata_i,
  input  logic              re_i,
  input  logic [IdxW-1:0]   raddr_i,
  output psa_pkg::entry_t   rdata_o
);
  import psa_pkg::*;

  entry_t                mem [NumEntries];
  logic [NumEntries-1:0] valid_q;
  entry_t                rdata_q;
  logic                  rvalid_q;

  // never-written entries read as empty, priority and wait zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== hdl/priority_scheduler_with_aging.sv =====
// channel  | dir | payload                                      | transfer
// in_i     | in  | opcode, entry_index, new_priority            | valid & ready
// out_o    | out | grant_valid, grant_index, grant_priority     | valid & ready
// cfg_i    | in  | index, data                                  | valid & ready
// load: entry write on accept, then the done step; finish: read, mark finished, done
// slice: a scan pass over all entries, then an aging pass when a grant was found
//   and aging is on, then the done step; one entry memory read per cycle over the
//   scan pass and the aging pass
// reset: no clearing pass, per-entry valid bits clear at once
// a waiting result does not block the next accept; the result register
//   must be free before the following one is written
module priority_scheduler_with_aging #(
  parameter int unsigned NUM_ENTRIES = psa_pkg::NUM_ENTRIES_DEF
) (
  input logic    clk_i,
  input logic    rst_ni,
  psa_in_if.sink   in_i,
  psa_out_if.source out_o,
  psa_cfg_if.sink  cfg_i
);
  import psa_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIN,
    S_SCAN,
    S_AGE,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [LEN_W-1:0]   slice_len_q;
  logic [LEN_W-1:0]   thresh_q;
  logic               aging_en_q;
  logic               found_q;
  logic [IdxW-1:0]    best_idx_q;
  logic [PRIO_W-1:0]  best_prio_q;
  logic [IdxW-1:0]    rd_idx_q;
  logic               out_vld_q;
  logic               grant_vld_q;
  logic [INDEX_W-1:0] grant_idx_q;
  logic [PRIO_W-1:0]  grant_prio_q;

  logic                   in_acc;
  logic                   idx_ok;
  logic [IdxW+INDEX_W-1:0] idx_ext;
  logic [IdxW-1:0]        idx_addr;
  logic [IdxW+INDEX_W-1:0] best_ext;
  logic                   last;
  logic                   better;
  logic                   found_any;
  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr;
  entry_t                 mem_wdata;
  logic                   mem_re;
  logic [IdxW-1:0]        mem_raddr;
  entry_t                 rdata;
  entry_t                 aged;
  logic [WAIT_W-1:0]      wait_sum;
  logic                   wait_hit;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign idx_ext  = {IdxW'(0), in_i.entry_index};
  assign idx_addr = idx_ext[IdxW-1:0];
  assign idx_ok   = (32'(in_i.entry_index) < NUM_ENTRIES);
  assign best_ext = {INDEX_W'(0), best_idx_q};

  assign last      = (rd_idx_q == LastIdx);
  assign better    = (rdata.st == ST_READY) && (!found_q || (rdata.prio > best_prio_q));
  assign found_any = found_q || (rdata.st == ST_READY);

  assign wait_sum = rdata.wait_time + WAIT_W'(slice_len_q);
  assign wait_hit = (wait_sum >= WAIT_W'(thresh_q));

  always_comb begin
    aged = rdata;
    if (wait_hit) begin
      aged.wait_time = '0;
      if (rdata.prio != PRIO_MAX) begin
        aged.prio = rdata.prio + PRIO_W'(1);
      end
    end else begin
      aged.wait_time = wait_sum;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_addr;
    mem_wdata = '{st: ST_READY, prio: in_i.new_priority, wait_time: '0};
    mem_re    = 1'b0;
    mem_raddr = idx_addr;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op_e'(in_i.opcode))
            OP_LOAD:   mem_we = idx_ok;
            OP_FINISH: mem_re = idx_ok;
            OP_SLICE: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
            end
            default: ;
          endcase
        end
      end
      S_FIN: begin
        mem_we       = 1'b1;
        mem_waddr    = rd_idx_q;
        mem_wdata    = rdata;
        mem_wdata.st = ST_FINISHED;
      end
      S_SCAN: begin
        mem_re = !last || (found_any && aging_en_q);
        mem_raddr = last ? '0 : rd_idx_q + IdxW'(1);
      end
      S_AGE: begin
        mem_we    = (rdata.st == ST_READY);
        mem_waddr = rd_idx_q;
        mem_wdata = aged;
        mem_re    = !last;
        mem_raddr = rd_idx_q + IdxW'(1);
      end
      default: ;
    endcase
  end

  psa_entry_mem #(
    .NumEntries(NUM_ENTRIES)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_len_q <= SLICE_LENGTH_RST;
      thresh_q    <= AGING_THRESH_RST;
      aging_en_q  <= AGING_ENABLE_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_SLICE_LENGTH:    slice_len_q <= cfg_i.data;
        CFG_AGING_THRESHOLD: thresh_q    <= cfg_i.data;
        CFG_AGING_ENABLE:    aging_en_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      best_prio_q  <= '0;
      rd_idx_q     <= '0;
      out_vld_q    <= 1'b0;
      grant_vld_q  <= 1'b0;
      grant_idx_q  <= '0;
      grant_prio_q <= '0;
    end else begin
      if (mem_re) begin
        rd_idx_q <= mem_raddr;
      end
      if (out_vld_q && out_o.ready && state_q != S_DONE) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            found_q     <= 1'b0;
            best_idx_q  <= '0;
            best_prio_q <= '0;
            case (op_e'(in_i.opcode))
              OP_FINISH: state_q <= idx_ok ? S_FIN : S_DONE;
              OP_SLICE:  state_q <= S_SCAN;
              default:   state_q <= S_DONE;
            endcase
          end
        end
        S_FIN: state_q <= S_DONE;
        S_SCAN: begin
          if (better) begin
            found_q     <= 1'b1;
            best_idx_q  <= rd_idx_q;
            best_prio_q <= rdata.prio;
          end
          if (last) begin
            state_q <= (found_any && aging_en_q) ? S_AGE : S_DONE;
          end
        end
        S_AGE: begin
          if (last) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q    <= 1'b1;
            grant_vld_q  <= found_q;
            grant_idx_q  <= found_q ? best_ext[INDEX_W-1:0] : '0;
            grant_prio_q <= found_q ? best_prio_q : '0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.grant_valid    = grant_vld_q;
  assign out_o.grant_index    = grant_idx_q;
  assign out_o.grant_priority = grant_prio_q;

  a_no_same_entry_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("entry written and read in the same cycle");

  a_age_needs_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_AGE |-> found_q && aging_en_q)
    else $error("aging pass without a grant or with aging off");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == S_DONE)
    else $error("result written outside the done step");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted item did not start work");

  a_grant_is_ready_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN && found_q |-> best_prio_q >= $past(best_prio_q) || $past(state_q) != S_SCAN)
    else $error("best priority dropped during scan");

endmodule
